// ----- rtl/ucb_pkg.sv -----
// Shared types and constants for the UCB1-Tuned child selector.
// Used by ucb_div, ucb_sqrt, the top level and the checker; no dependencies.
package ucb_pkg;

  localparam int MAX_CHILDREN = 512;
  localparam int IDX_W        = $clog2(MAX_CHILDREN);

  localparam int DIV_NW = 53;   // dividend width
  localparam int DIV_DW = 25;   // divisor width
  localparam int DIV_QW = 33;   // widest quotient
  localparam int DIV_CW = 6;    // quotient bit count field

  localparam int SQ_XW = 38;    // radicand width
  localparam int SQ_RW = 19;    // root width

  localparam logic [31:0] LN2_Q32      = 32'd2977044472;
  localparam logic [24:0] DRAW_DIVISOR = 25'd10000;
  localparam logic [29:0] DRAW_ROUND   = 30'd5000;
  // (draw * 65536 + 5000) / 10000 == (draw * 4096 + 312) / 625, taken as a
  // product with ceil(2^36 / 625) and a 36-bit right shift
  localparam logic [11:0] DRAW_BIAS    = 12'd312;
  localparam logic [31:0] DRAW_RECIP   = 32'd109951163;
  localparam logic [14:0] VAR_CAP      = 15'd16384;

  localparam logic [1:0] REG_WEIGHT  = 2'd0;
  localparam logic [1:0] REG_EQUIV   = 2'd1;
  localparam logic [1:0] REG_FPU     = 2'd2;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
    logic [DIV_CW-1:0] qbits;
  } div_req_t;

  typedef struct packed {
    logic             start;
    logic [SQ_XW-1:0] x;
  } sqrt_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_NORM,
    S_LN_MUL,
    S_LN_SQ,
    S_LN_SCALE,
    S_LN_DONE,
    S_RATIO,
    S_RATIO_WAIT,
    S_WSQ_WAIT,
    S_WMUL,
    S_CHILD,
    S_DRAW_WAIT,
    S_P_WAIT,
    S_D_WAIT,
    S_PP,
    S_SQ_WAIT,
    S_DV,
    S_E_WAIT,
    S_UPDATE,
    S_EMIT
  } state_t;

endpackage

// ----- rtl/ucb_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on ucb_pkg for widths and the request struct.
module ucb_div (
  input  logic                       clk,
  input  logic                       rst,
  input  ucb_pkg::div_req_t          req,
  output logic                       done,
  output logic [ucb_pkg::DIV_QW-1:0] quot
);
  import ucb_pkg::*;

  localparam int SW = DIV_DW + DIV_QW;

  logic              busy;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_NW-1:0] rem;
  logic [SW-1:0]     dsh;
  logic              fits;

  assign fits = {{(SW-DIV_NW){1'b0}}, rem} >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DIV_CW'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.qbits;
      end else if (busy) begin
        cnt <= cnt - DIV_CW'(1);
        if (cnt == DIV_CW'(1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.dividend;
      dsh  <= SW'(req.divisor) << (req.qbits - DIV_CW'(1));
      quot <= '0;
    end else if (busy) begin
      // subtract the shifted divisor where it fits
      if (fits) rem <= rem - dsh[DIV_NW-1:0];
      quot <= {quot[DIV_QW-2:0], fits};
      dsh  <= dsh >> 1;
    end
  end

endmodule

// ----- rtl/ucb_sqrt.sv -----
// Bitwise floor square root, one result bit per cycle.
// Depends on ucb_pkg for widths and the request struct.
module ucb_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  ucb_pkg::sqrt_req_t        req,
  output logic                      done,
  output logic [ucb_pkg::SQ_RW-1:0] root
);
  import ucb_pkg::*;

  localparam int CW = $clog2(SQ_RW + 1);

  logic           busy;
  logic [CW-1:0]  cnt;
  logic [SQ_XW-1:0] xr;
  logic [SQ_XW:0]   acc;
  logic [SQ_XW-1:0] bitv;
  logic [SQ_XW:0]   trial;

  assign trial = acc + {1'b0, bitv};
  assign root  = acc[SQ_RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(SQ_RW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      xr   <= req.x;
      acc  <= '0;
      bitv <= SQ_XW'(1) << (2 * (SQ_RW - 1));
    end else if (busy) begin
      if ({1'b0, xr} >= trial) begin
        xr  <= xr - trial[SQ_XW-1:0];
        acc <= (acc >> 1) + {1'b0, bitv};
      end else begin
        acc <= acc >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

// ----- rtl/ucb1_tuned_child_select.sv -----
// UCB1-Tuned child selector: top level with sequencer, shared multiplier and APB registers.
// Depends on ucb_pkg, ucb_div and ucb_sqrt.
//
// Children of one tree node arrive one transaction each; the block returns one result
// transaction (best index, its Q8.16 score, found flag) on the child marked last.
// Each child is worked on alone and in_ready drops until it is done. An unvisited
// child gets its tie noise from one reciprocal product, and a visited child takes
// two divisions (17 and 21 quotient bits), two 19-bit square roots and three products,
// all through one shared divider, one shared square-root unit and one 32x32 multiplier,
// each divider and root step retiring one bit per cycle. A child marked last also
// loads the result. A child that opens a node first runs the normalize shift, the
// 16 squaring steps of the parent log, its scaling, the 33-bit ratio division, its
// square root and the weight product. A result waits in the output register while
// the next child is taken.
module ucb1_tuned_child_select (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        first_child,
  input  logic        last_child,
  input  logic [23:0] parent_visits,
  input  logic [23:0] child_move_count,
  input  logic [15:0] child_virtual_loss,
  input  logic [23:0] child_wins,
  input  logic [15:0] move_rate,
  input  logic        widened,
  input  logic        opened,
  input  logic [13:0] random_draw,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [ucb_pkg::IDX_W-1:0] best_index,
  output logic signed [23:0] best_score,
  output logic        found,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ucb_pkg::*;

  // configuration
  logic [19:0] weight_q16;
  logic [19:0] equiv_visits;
  logic [19:0] first_play_urgency;

  state_t st, st_next;

  // latched transaction
  logic        last_r, sel_r;
  logic [23:0] pv_r, mc_r, wins_r;
  logic [15:0] vl_r, rate_r;
  logic [13:0] draw_r;

  // node and child working registers
  logic [31:0] y;
  logic [4:0]  k;
  logic [15:0] frac;
  logic [3:0]  lcnt;
  logic [20:0] plog, nbw, dval;
  logic [16:0] pval, ppv;
  logic [24:0] score;
  logic [23:0] best_sc;
  logic [IDX_W-1:0] best_ix, counter, pos;
  logic        have;

  // shared multiplier
  logic        mul_en;
  logic [31:0] ma, mb;
  logic [63:0] prod;

  div_req_t    div_req;
  sqrt_req_t   sq_req;
  logic        div_done, sq_done;
  logic [DIV_QW-1:0] div_quot;
  logic [SQ_RW-1:0]  sq_root;

  logic [24:0] n_sum, den;
  logic [23:0] wins_c;
  logic [32:0] t_sq;
  logic [19:0] v_sum;
  logic [14:0] v_cap;
  logic        out_free;

  assign n_sum    = {1'b0, mc_r} + {9'b0, vl_r};
  assign den      = {1'b0, pv_r} + {5'b0, equiv_visits};
  assign wins_c   = ({1'b0, wins_r} > n_sum) ? n_sum[23:0] : wins_r;
  assign t_sq     = prod[63:31];
  assign v_sum    = {3'b0, pval} - {3'b0, ppv} + {1'b0, sq_root};
  assign v_cap    = (v_sum > {5'b0, VAR_CAP}) ? VAR_CAP : v_sum[14:0];
  assign out_free = !out_valid || out_ready;

  ucb_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  ucb_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (sq_req),
    .done (sq_done),
    .root (sq_root)
  );

  // APB registers; writes land on the access phase
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      REG_WEIGHT: prdata = {12'b0, weight_q16};
      REG_EQUIV:  prdata = {12'b0, equiv_visits};
      REG_FPU:    prdata = {12'b0, first_play_urgency};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_q16         <= 20'd22938;
      equiv_visits       <= 20'd1000;
      first_play_urgency <= 20'd327680;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_WEIGHT: weight_q16         <= pwdata[19:0];
        REG_EQUIV:  equiv_visits       <= pwdata[19:0];
        REG_FPU:    first_play_urgency <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  // sequencer: next state
  always_comb begin
    st_next = st;
    unique case (st)
      S_IDLE:       if (in_valid) st_next = first_child ? S_NORM : S_CHILD;
      S_NORM: begin
        if (pv_r <= 24'd1)  st_next = S_RATIO;
        else if (y[31])     st_next = S_LN_MUL;
      end
      S_LN_MUL:     st_next = S_LN_SQ;
      S_LN_SQ:      st_next = (lcnt == 4'd15) ? S_LN_SCALE : S_LN_MUL;
      S_LN_SCALE:   st_next = S_LN_DONE;
      S_LN_DONE:    st_next = S_RATIO;
      S_RATIO:      st_next = (den == '0) ? S_WSQ_WAIT : S_RATIO_WAIT;
      S_RATIO_WAIT: if (div_done) st_next = S_WSQ_WAIT;
      S_WSQ_WAIT:   if (sq_done) st_next = S_WMUL;
      S_WMUL:       st_next = S_CHILD;
      S_CHILD: begin
        if (!sel_r)              st_next = S_UPDATE;
        else if (n_sum == '0)    st_next = S_DRAW_WAIT;
        else                     st_next = S_P_WAIT;
      end
      S_DRAW_WAIT:  st_next = S_UPDATE;
      S_P_WAIT:     if (div_done) st_next = S_D_WAIT;
      S_D_WAIT:     if (div_done) st_next = S_PP;
      S_PP:         st_next = S_SQ_WAIT;
      S_SQ_WAIT:    if (sq_done) st_next = S_DV;
      S_DV:         st_next = S_E_WAIT;
      S_E_WAIT:     if (sq_done) st_next = S_UPDATE;
      S_UPDATE:     st_next = last_r ? S_EMIT : S_IDLE;
      S_EMIT:       if (out_free) st_next = S_IDLE;
      default:      st_next = S_IDLE;
    endcase
  end

  // sequencer: unit requests and multiplier operands
  always_comb begin
    in_ready = 1'b0;
    div_req  = '0;
    sq_req   = '0;
    mul_en   = 1'b0;
    ma       = '0;
    mb       = '0;
    unique case (st)
      S_IDLE: in_ready = 1'b1;
      S_LN_MUL: begin
        mul_en = 1'b1;
        ma     = y;
        mb     = y;
      end
      S_LN_SCALE: begin
        mul_en = 1'b1;
        ma     = {11'b0, k, frac};
        mb     = LN2_Q32;
      end
      S_RATIO: begin
        // equivalence over (visits + equivalence), Q1.32; 1.0 when both are zero
        if (den == '0) begin
          sq_req.start = 1'b1;
          sq_req.x     = SQ_XW'(64'h1_0000_0000);
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {1'b0, equiv_visits, 32'b0};
          div_req.divisor  = den;
          div_req.qbits    = DIV_CW'(33);
        end
      end
      S_RATIO_WAIT: begin
        sq_req.start = div_done;
        sq_req.x     = SQ_XW'(div_quot);
      end
      S_WSQ_WAIT: begin
        mul_en = sq_done;
        ma     = {12'b0, weight_q16};
        mb     = {13'b0, sq_root};
      end
      S_CHILD: begin
        if (sel_r && n_sum == '0) begin
          // rounded draw * 65536 / 10000 through the reciprocal of 625
          mul_en = 1'b1;
          ma     = {6'b0, draw_r, DRAW_BIAS};
          mb     = DRAW_RECIP;
        end else if (sel_r) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_NW'({wins_c, 16'b0});
          div_req.divisor  = n_sum;
          div_req.qbits    = DIV_CW'(17);
        end
      end
      S_P_WAIT: begin
        div_req.start    = div_done;
        div_req.dividend = DIV_NW'(plog);
        div_req.divisor  = n_sum;
        div_req.qbits    = DIV_CW'(21);
      end
      S_D_WAIT: begin
        mul_en = div_done;
        ma     = {15'b0, pval};
        mb     = {15'b0, pval};
      end
      S_PP: begin
        sq_req.start = 1'b1;
        sq_req.x     = {dval, 17'b0};
      end
      S_SQ_WAIT: begin
        mul_en = sq_done;
        ma     = {11'b0, dval};
        mb     = {17'b0, v_cap};
      end
      S_DV: begin
        sq_req.start = 1'b1;
        sq_req.x     = prod[SQ_XW-1:0];
        mul_en       = 1'b1;
        ma           = {11'b0, nbw};
        mb           = {16'b0, rate_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= S_IDLE;
    else     st <= st_next;
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod <= ma * mb;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      have      <= 1'b0;
      counter   <= '0;
      best_sc   <= '0;
      best_ix   <= '0;
      out_valid <= 1'b0;
      plog      <= '0;
      nbw       <= '0;
      pv_r      <= '0;
    end else begin
      // load a result, or drop valid once the waiting one is taken
      if (st == S_EMIT && out_free) out_valid <= 1'b1;
      else if (out_ready)           out_valid <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (in_valid && first_child) begin
            // open a new node
            pv_r    <= parent_visits;
            have    <= 1'b0;
            best_sc <= '0;
            best_ix <= '0;
            counter <= '0;
          end
        end
        S_NORM:    if (pv_r <= 24'd1) plog <= '0;
        S_LN_DONE: plog <= prod[52:32];
        S_WMUL:    nbw  <= prod[36:16];
        S_CHILD:   counter <= counter + IDX_W'(1);
        S_UPDATE: begin
          if (sel_r && (!have || score > {1'b0, best_sc})) begin
            have    <= 1'b1;
            best_sc <= score[23:0];
            best_ix <= pos;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            have      <= 1'b0;
            best_sc   <= '0;
            best_ix   <= '0;
            counter   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (st)
      S_IDLE: begin
        if (in_valid) begin
          last_r <= last_child;
          sel_r  <= widened || opened;
          mc_r   <= child_move_count;
          vl_r   <= child_virtual_loss;
          wins_r <= child_wins;
          rate_r <= move_rate;
          draw_r <= random_draw;
          y      <= {parent_visits, 8'b0};
          k      <= 5'd23;
          frac   <= '0;
          lcnt   <= '0;
        end
      end
      S_NORM: begin
        // shift the leading one up to bit 31
        if (!y[31]) begin
          y <= y << 1;
          k <= k - 5'd1;
        end
      end
      S_LN_SQ: begin
        lcnt <= lcnt + 4'd1;
        if (t_sq[32]) begin
          y    <= t_sq[32:1];
          frac <= {frac[14:0], 1'b1};
        end else begin
          y    <= t_sq[31:0];
          frac <= {frac[14:0], 1'b0};
        end
      end
      S_CHILD:     pos   <= counter;
      S_DRAW_WAIT: score <= {5'b0, first_play_urgency} + {8'b0, prod[52:36]};
      S_P_WAIT:    if (div_done) pval  <= div_quot[16:0];
      S_D_WAIT:    if (div_done) dval  <= div_quot[20:0];
      S_PP:        ppv <= prod[32:16];
      S_E_WAIT: begin
        if (sq_done) begin
          score <= {8'b0, pval} + {6'b0, sq_root} + {4'b0, prod[36:16]};
        end
      end
      S_EMIT: begin
        if (out_free) begin
          best_index <= have ? best_ix : '0;
          best_score <= have ? best_sc : '0;
          found      <= have;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/ucb_chk.sv -----
// Port-level checker for the UCB1-Tuned child selector, bound to the top level.
// Depends on ucb_pkg for the index width.
module ucb_chk (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [ucb_pkg::IDX_W-1:0] best_index,
  input logic [23:0]               best_score,
  input logic                      found
);
  import ucb_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(best_index) &&
      $stable(best_score) && $stable(found))
    else $error("result changed while stalled");

  a_none: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> best_index == '0 && best_score == '0)
    else $error("empty result carries index or score");

  a_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> !best_score[23])
    else $error("negative score");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("took a transaction while working");

endmodule

bind ucb1_tuned_child_select ucb_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .best_index (best_index),
  .best_score (best_score),
  .found      (found)
);

// ----- tb/sv/tb_ucb1_tuned_child_select.sv -----
// Self-checking testbench for ucb1_tuned_child_select: drives child transactions and
// APB register writes, predicts every best-child result and compares it field by field.
// Depends on ucb_pkg and the RTL of ucb1_tuned_child_select.
module tb_ucb1_tuned_child_select;
  timeunit 1ns;
  timeprecision 1ps;
  import ucb_pkg::*;

  typedef struct {
    bit        first;
    bit        last;
    bit [23:0] parent_visits;
    bit [23:0] visits;
    bit [15:0] vloss;
    bit [23:0] wins;
    bit [15:0] rate;
    bit        widened;
    bit        opened;
    bit [13:0] draw;
  } child_t;

  typedef struct {
    bit [8:0]  index;
    bit [23:0] score;
    bit        found;
  } pick_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid, in_ready;
  logic        first_child, last_child;
  logic [23:0] parent_visits, child_move_count, child_wins;
  logic [15:0] child_virtual_loss, move_rate;
  logic        widened, opened;
  logic [13:0] random_draw;
  logic        out_valid, out_ready;
  logic [IDX_W-1:0] best_index;
  logic signed [23:0] best_score;
  logic        found;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  ucb1_tuned_child_select dut (
    .clk, .rst, .in_valid, .in_ready, .first_child, .last_child, .parent_visits,
    .child_move_count, .child_virtual_loss, .child_wins, .move_rate, .widened,
    .opened, .random_draw, .out_valid, .out_ready, .best_index, .best_score, .found,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the registers and of the per-node selection state.
  bit [19:0] weight_reg, equiv_reg, urgency_reg;
  bit [23:0] lead_score;
  bit [8:0]  lead_index;
  bit        lead_valid;
  bit [8:0]  child_pos;
  bit [31:0] node_weight;
  bit [31:0] node_log;

  pick_t expected_picks[$];
  int    failures = 0;
  int    children_sent = 0;
  int    picks_checked = 0;
  int    picks_found = 0;

  // Sender pacing: bursts of back-to-back children separated by random gaps.
  int    burst_left = 0;
  int    gap_next = 0;
  bit    pacing_on = 1'b1;

  function automatic bit [63:0] floor_sqrt(bit [63:0] x);
    bit [63:0] root = 0;
    bit [63:0] b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= root + b) begin
        x = x - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // Natural log of a visit count in Q8.16 via a squaring log2.
  function automatic bit [31:0] visits_ln(bit [31:0] x);
    bit [31:0] k = 0;
    bit [63:0] y;
    bit [31:0] frac = 0;
    bit [63:0] lin;
    if (x <= 1) return 0;
    while (k < 31 && (x >> (k + 1)) != 0) k++;
    y = {32'b0, x} << (31 - k);
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 31;
      frac = frac << 1;
      if (y >= 64'h1_0000_0000) begin
        y = y >> 1;
        frac = frac | 1;
      end
    end
    lin = {32'b0, k} * 65536 + frac;
    return 32'((lin * {32'b0, LN2_Q32}) >> 32);
  endfunction

  function automatic void open_node(bit [23:0] visits);
    bit [63:0] den = {40'b0, visits} + {44'b0, equiv_reg};
    bit [63:0] ratio;
    node_log = visits_ln({8'b0, visits});
    if (den == 0) ratio = 64'd1 << 32;
    else ratio = ({44'b0, equiv_reg} << 32) / den;
    node_weight = 32'(({44'b0, weight_reg} * floor_sqrt(ratio)) >> 16);
    lead_valid = 1'b0;
    lead_score = 0;
    lead_index = 0;
    child_pos = 0;
  endfunction

  function automatic bit [31:0] tuned_score(bit [63:0] n, bit [63:0] w, bit [15:0] rate);
    bit [63:0] p, d, v, sq, pp;
    if (w > n) w = n;
    p = (w << 16) / n;
    d = {32'b0, node_log} / n;
    pp = (p * p) >> 16;
    sq = floor_sqrt((2 * d) << 16);
    v = p - pp + sq;
    if (v > VAR_CAP) v = VAR_CAP;
    return 32'(p + floor_sqrt(d * v) + (({32'b0, node_weight} * rate) >> 16));
  endfunction

  // Advance the shadow state by one accepted child; queue a pick on the last one.
  function automatic void predict_child(child_t c);
    bit [8:0]  pos;
    bit [63:0] n;
    bit [31:0] score;
    pick_t     pk;
    if (c.first) open_node(c.parent_visits);
    pos = child_pos;
    child_pos = pos + 1;
    if (c.widened || c.opened) begin
      n = {40'b0, c.visits} + {48'b0, c.vloss};
      if (n == 0)
        score = urgency_reg + 32'(({50'b0, c.draw} * 65536 + DRAW_ROUND) / DRAW_DIVISOR);
      else
        score = tuned_score(n, {40'b0, c.wins}, c.rate);
      if (!lead_valid || score > {8'b0, lead_score}) begin
        lead_valid = 1'b1;
        lead_score = score[23:0];
        lead_index = pos;
      end
    end
    if (c.last) begin
      pk.index = lead_valid ? lead_index : 9'd0;
      pk.score = lead_valid ? lead_score : 24'd0;
      pk.found = lead_valid;
      expected_picks.push_back(pk);
      lead_valid = 1'b0;
      lead_score = 0;
      lead_index = 0;
      child_pos = 0;
    end
  endfunction

  // Send one child: hold valid and payload until the block takes it, then predict.
  task automatic send_child(child_t c);
    if (gap_next > 0) repeat (gap_next) @(posedge clk);
    in_valid           <= 1'b1;
    first_child        <= c.first;
    last_child         <= c.last;
    parent_visits      <= c.parent_visits;
    child_move_count   <= c.visits;
    child_virtual_loss <= c.vloss;
    child_wins         <= c.wins;
    move_rate          <= c.rate;
    widened            <= c.widened;
    opened             <= c.opened;
    random_draw        <= c.draw;
    do @(posedge clk); while (!in_ready);
    predict_child(c);
    children_sent++;
    gap_next = 0;
    if (pacing_on) begin
      if (burst_left == 0) begin
        gap_next = $urandom_range(1, 12);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
    if (gap_next > 0) in_valid <= 1'b0;
  endtask

  // Drop valid, wait for every pick to come back, then let the block settle.
  task automatic drain();
    if (gap_next == 0) in_valid <= 1'b0;
    gap_next = 0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [19:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {12'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WEIGHT: weight_reg = value;
      REG_EQUIV:  equiv_reg = value;
      REG_FPU:    urgency_reg = value;
      default: ;
    endcase
  endtask

  task automatic set_regs(bit [19:0] w, bit [19:0] e, bit [19:0] u);
    write_reg(REG_WEIGHT, w);
    write_reg(REG_EQUIV, e);
    write_reg(REG_FPU, u);
  endtask

  function automatic child_t make_child(bit first, bit last, bit [23:0] pv, bit [23:0] mc,
                                        bit [15:0] vl, bit [23:0] w, bit [15:0] rate,
                                        bit sel, bit [13:0] draw);
    child_t c;
    c.first = first; c.last = last; c.parent_visits = pv; c.visits = mc;
    c.vloss = vl; c.wins = w; c.rate = rate; c.widened = sel; c.opened = 1'b0;
    c.draw = draw;
    return c;
  endfunction

  function automatic bit [23:0] rand_magnitude();
    int bits = $urandom_range(0, 24);
    return 24'($urandom & ((33'd1 << bits) - 1));
  endfunction

  function automatic child_t rand_child(bit first, bit last);
    child_t c;
    c.first = first;
    c.last = last;
    c.parent_visits = rand_magnitude();
    if ($urandom_range(0, 9) < 3) begin
      c.visits = 0;
      c.vloss = 0;
    end else begin
      c.visits = rand_magnitude();
      c.vloss = ($urandom_range(0, 9) < 7) ? 16'd0 : 16'($urandom);
    end
    if ($urandom_range(0, 9) < 8 && c.visits != 0)
      c.wins = 24'($urandom_range(0, c.visits));
    else
      c.wins = 24'($urandom);
    c.rate = 16'($urandom);
    c.widened = $urandom_range(0, 1);
    c.opened = ($urandom_range(0, 9) < 7) ? 1'b1 : 1'($urandom_range(0, 1));
    c.draw = 14'($urandom_range(0, 9999));
    return c;
  endfunction

  // Extremes of fields, ties, wins above visits, empty nodes, zero parent visits.
  task automatic test_directed();
    child_t c;
    pacing_on = 1'b0;
    // Children before any node start use the reset node values.
    send_child(make_child(0, 0, 24'd5, 24'd10, 16'd0, 24'd3, 16'hFFFF, 1, 14'd0));
    send_child(make_child(0, 1, 24'd0, 24'd0, 16'd0, 24'd0, 16'd0, 1, 14'd9999));
    // No selectable child.
    send_child(make_child(1, 1, 24'd100, 24'd5, 16'd0, 24'd1, 16'd0, 0, 14'd0));
    // Parent visits zero, ties keep the earlier child.
    send_child(make_child(1, 0, 24'd0, 24'd7, 16'd0, 24'd2, 16'd100, 1, 14'd0));
    send_child(make_child(0, 0, 24'd0, 24'd7, 16'd0, 24'd2, 16'd100, 1, 14'd0));
    send_child(make_child(0, 1, 24'd0, 24'd0, 16'd0, 24'd0, 16'd0, 0, 14'd0));
    // Full-scale fields, wins above visits, virtual loss alone.
    send_child(make_child(1, 0, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 16'hFFFF,
                          1, 14'h3FFF & 14'd9999));
    send_child(make_child(0, 0, 24'd0, 24'd1, 16'd0, 24'hFFFFFF, 16'hFFFF, 1, 14'd0));
    send_child(make_child(0, 0, 24'd0, 24'd0, 16'hFFFF, 24'd0, 16'd1, 1, 14'd0));
    c = make_child(0, 0, 24'd0, 24'd0, 16'd0, 24'd0, 16'd0, 0, 14'd9999);
    c.opened = 1'b1;
    send_child(c);
    send_child(make_child(0, 1, 24'd1, 24'd1, 16'd1, 24'd1, 16'd1, 1, 14'd1));
    // After a result the next child starts a new selection without first_child, keeping the node values.
    send_child(make_child(0, 0, 24'd9, 24'd3, 16'd0, 24'd1, 16'd500, 1, 14'd0));
    send_child(make_child(0, 1, 24'd9, 24'd0, 16'd0, 24'd0, 16'd0, 1, 14'd4321));
    drain();
    // Urgency changes inside a node take effect at once; node weight stays latched.
    send_child(make_child(1, 0, 24'd50, 24'd0, 16'd0, 24'd0, 16'd0, 1, 14'd5000));
    send_child(make_child(0, 0, 24'd50, 24'd20, 16'd0, 24'd10, 16'hFFFF, 1, 14'd0));
    drain();
    set_regs(20'hFFFFF, 20'd1, 20'hFFFFF);
    send_child(make_child(0, 0, 24'd50, 24'd0, 16'd0, 24'd0, 16'd0, 1, 14'd0));
    send_child(make_child(0, 1, 24'd50, 24'd20, 16'd0, 24'd10, 16'hFFFF, 1, 14'd0));
    drain();
    // Equivalence and parent visits both zero.
    set_regs(20'd22938, 20'd0, 20'd0);
    send_child(make_child(1, 0, 24'd0, 24'd4, 16'd0, 24'd4, 16'hFFFF, 1, 14'd0));
    send_child(make_child(0, 1, 24'd0, 24'd0, 16'd0, 24'd0, 16'd0, 1, 14'd0));
    drain();
  endtask

  // More children than the position counter holds: the index wraps.
  task automatic test_counter_wrap();
    child_t c;
    pacing_on = 1'b0;
    set_regs(20'd0, 20'd1000, 20'd65536);
    for (int i = 0; i < 530; i++) begin
      c = make_child(i == 0, i == 529, 24'd1000, 24'd100, 16'd0, 24'd50, 16'd0,
                     (i % 97) == 0, 14'd0);
      if (i == 515) begin
        c.visits = 0;
        c.widened = 1'b1;
        c.draw = 14'd9999;
      end
      send_child(c);
    end
    drain();
  endtask

  // Random nodes under one register setting; mostly well-formed, some loose flags.
  task automatic test_random_nodes(int nodes, bit [19:0] w, bit [19:0] e, bit [19:0] u);
    int     len;
    child_t c;
    set_regs(w, e, u);
    pacing_on = ($urandom_range(0, 3) != 0);
    for (int k = 0; k < nodes; k++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        c = rand_child(i == 0, i == len - 1);
        if ($urandom_range(0, 19) == 0) begin
          c.first = $urandom_range(0, 1);
          c.last = $urandom_range(0, 1);
        end
        send_child(c);
      end
    end
    // Close any node left open by a loose flag.
    send_child(rand_child(0, 1));
    drain();
  endtask

  // Receiver stalls, with the pattern redrawn at random from a free-running tick counter.
  int unsigned stall_tick = 0;
  int unsigned stall_mode = 0;
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= stall_tick[2];
    endcase
  end

  // Compare each result transaction with the oldest predicted pick.
  always @(posedge clk) begin
    pick_t pk;
    if (!rst && out_valid && out_ready) begin
      if (expected_picks.size() == 0) begin
        $display("%0t: unexpected result index %0d score %0d found %0d", $realtime,
                 best_index, best_score, found);
        failures++;
      end else begin
        pk = expected_picks.pop_front();
        picks_checked++;
        if (pk.found) picks_found++;
        if (best_index !== pk.index) begin
          $display("%0t: best_index expected %0d actual %0d", $realtime, pk.index, best_index);
          failures++;
        end
        if (best_score !== pk.score) begin
          $display("%0t: best_score expected %0d actual %0d", $realtime,
                   $signed(pk.score), best_score);
          failures++;
        end
        if (found !== pk.found) begin
          $display("%0t: found expected %0d actual %0d", $realtime, pk.found, found);
          failures++;
        end
      end
    end
  end

  initial begin
    in_valid <= 1'b0; first_child <= 1'b0; last_child <= 1'b0;
    parent_visits <= 0; child_move_count <= 0; child_virtual_loss <= 0; child_wins <= 0;
    move_rate <= 0; widened <= 1'b0; opened <= 1'b0; random_draw <= 0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= 0; pwdata <= 0;
    out_ready <= 1'b1;
    weight_reg = 20'd22938; equiv_reg = 20'd1000; urgency_reg = 20'd327680;
    lead_score = 0; lead_index = 0; lead_valid = 0; child_pos = 0;
    node_weight = 0; node_log = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_counter_wrap();
    test_random_nodes(15, 20'd22938, 20'd1000, 20'd327680);
    test_random_nodes(10, 20'd0, 20'd1, 20'd0);
    test_random_nodes(10, 20'hFFFFF, 20'd1000000, 20'hFFFFF);
    test_random_nodes(10, 20'($urandom), 20'($urandom_range(1, 1000000)), 20'($urandom));
    test_random_nodes(10, 20'($urandom), 20'($urandom_range(1, 50)), 20'($urandom));
    $display("covered %0d child transactions and %0d picks (%0d with a selectable child)",
             children_sent, picks_checked, picks_found);
    $display("register settings: reset values, both extremes and random; %0d mismatches",
             failures);
    if (failures == 0 && expected_picks.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d picks outstanding", expected_picks.size());
    $display("status: fail");
    $finish;
  end

endmodule
